>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks in the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define MACS_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MACS_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

>>> rtl/macs_pkg.sv
// ----------------------------------------------------------------------------
// macs_pkg
// Types and constants shared by the modem AT command sequencer modules.
// ----------------------------------------------------------------------------
package macs_pkg;

  localparam logic [15:0] BOOT_WAIT_RST      = 16'd11200;
  localparam logic [15:0] CMD_TIMEOUT_RST    = 16'd2000;
  localparam logic [15:0] ACTION_TIMEOUT_RST = 16'd10000;
  localparam logic [15:0] SETTLE_RST         = 16'd50;
  localparam logic [15:0] ELAPSED_MAX        = 16'hFFFF;

  typedef enum logic [1:0] {
    REG_BOOT_WAIT      = 2'd0,
    REG_CMD_TIMEOUT    = 2'd1,
    REG_ACTION_TIMEOUT = 2'd2,
    REG_SETTLE         = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_RESPONSE  = 3'd1,
    CMD_POWER_ON  = 3'd2,
    CMD_POWER_OFF = 3'd3,
    CMD_WAKE      = 3'd4,
    CMD_SEND      = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OFF   = 3'd0,
    ST_BOOT  = 3'd1,
    ST_NET   = 3'd2,
    ST_SLEEP = 3'd3,
    ST_TX    = 3'd4,
    ST_WAIT  = 3'd5,
    ST_BUSY  = 3'd6
  } state_t;

  typedef enum logic [2:0] {
    HS_IDLE   = 3'd0,
    HS_INIT   = 3'd1,
    HS_URL    = 3'd2,
    HS_ACTION = 3'd3,
    HS_DONE   = 3'd4
  } http_step_t;

  typedef enum logic [1:0] {
    CS_ECHO  = 2'd0,
    CS_APN   = 2'd1,
    CS_SLEEP = 2'd2,
    CS_DONE  = 2'd3
  } config_step_t;

  typedef enum logic [2:0] {
    SEND_NONE       = 3'd0,
    SEND_ECHO_OFF   = 3'd1,
    SEND_APN_SET    = 3'd2,
    SEND_SLEEP_EN   = 3'd3,
    SEND_HTTP_INIT  = 3'd4,
    SEND_URL        = 3'd5,
    SEND_HTTP_ACT   = 3'd6,
    SEND_HTTP_TERM  = 3'd7
  } send_t;

  typedef enum logic [1:0] {
    DTR_NONE = 2'd0,
    DTR_LOW  = 2'd1,
    DTR_HIGH = 2'd2
  } dtr_t;

  typedef enum logic [1:0] {
    PWR_NONE = 2'd0,
    PWR_ON   = 2'd1,
    PWR_OFF  = 2'd2
  } pwr_t;

  localparam int FLAG_OK    = 0;
  localparam int FLAG_200   = 1;
  localparam int FLAG_ERROR = 2;

  typedef struct packed {
    logic [15:0] boot_wait_ms;
    logic [15:0] command_timeout_ms;
    logic [15:0] action_timeout_ms;
    logic [15:0] settle_ms;
  } cfg_t;

  typedef struct packed {
    cmd_t command;
    logic has_ok;
    logic has_code_200;
    logic has_error;
    logic payload_nonempty;
  } item_t;

  typedef struct packed {
    state_t       main_state;
    http_step_t   http_step;
    config_step_t config_step;
    logic [15:0]  elapsed_ms;
    logic [15:0]  wait_limit;
    logic         response_pending;
    logic [2:0]   response_flags;
  } seq_state_t;

  typedef struct packed {
    state_t modem_state;
    send_t  send_code;
    dtr_t   dtr_drive;
    pwr_t   pwrkey_pulse;
    logic   done_valid;
    logic   done_success;
  } result_t;

endpackage

>>> rtl/modem_at_command_sequencer_unit.sv
// ----------------------------------------------------------------------------
// modem_at_command_sequencer_unit
// AT command sequencer for a cellular modem: boot, configuration, light sleep
// and a four-command HTTP GET; all commands bar the last use response timeouts.
// ----------------------------------------------------------------------------
// One request is accepted per clock cycle while the input side is not stalled,
// and each produces exactly one result. A request is held in an input
// register, passes through the sequencer update once the output register
// has room and is registered into the output register, where the result
// waits until it is taken. The output register frees the input side: a new
// request is taken while a finished result waits, and the input register
// stalls only when the output register is full and not being drained.
// Configuration registers are written through a plain write port.
module modem_at_command_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  command,
  input  logic        has_ok,
  input  logic        has_code_200,
  input  logic        has_error,
  input  logic        payload_nonempty,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  modem_state,
  output logic [2:0]  send_code,
  output logic [1:0]  dtr_drive,
  output logic [1:0]  pwrkey_pulse,
  output logic        done_valid,
  output logic        done_success
);
  import macs_pkg::*;

  `include "assert_macros.svh"

  cfg_t    cfg;
  item_t   item_q;
  logic    item_vld;
  result_t res_comb;
  result_t res_q;
  logic    res_vld;
  logic    advance;

  assign advance    = item_vld && (!res_vld || result_ready);
  assign item_ready = !item_vld || advance;

  macs_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (item_ready) begin
      item_vld <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= '{command: cmd_t'(command), has_ok: has_ok, has_code_200: has_code_200,
                  has_error: has_error, payload_nonempty: payload_nonempty};
    end
  end

  macs_step u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (item_q),
    .cfg  (cfg),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (advance) begin
      res_vld <= 1'b1;
    end else if (result_ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_comb;
    end
  end

  assign result_valid = res_vld;
  assign modem_state  = res_q.modem_state;
  assign send_code    = res_q.send_code;
  assign dtr_drive    = res_q.dtr_drive;
  assign pwrkey_pulse = res_q.pwrkey_pulse;
  assign done_valid   = res_q.done_valid;
  assign done_success = res_q.done_success;

  // A held request moves on whenever the output register has room.
  `MACS_ASSERT(a_no_idle_stall, clk, rst,
    (item_vld && !res_vld) |-> advance,
    "held request not advanced into an empty output register")

  // A success flag never appears without a completion.
  `MACS_ASSERT(a_success_needs_done, clk, rst,
    (res_vld && done_success) |-> done_valid,
    "success reported without a completion")

endmodule

>>> rtl/macs_regs.sv
// ----------------------------------------------------------------------------
// macs_regs
// Configuration register file with a plain write port and reset defaults.
// ----------------------------------------------------------------------------
module macs_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  output macs_pkg::cfg_t  cfg
);
  import macs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_wait_ms       <= BOOT_WAIT_RST;
      cfg.command_timeout_ms <= CMD_TIMEOUT_RST;
      cfg.action_timeout_ms  <= ACTION_TIMEOUT_RST;
      cfg.settle_ms          <= SETTLE_RST;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_BOOT_WAIT:      cfg.boot_wait_ms       <= cfg_data;
        REG_CMD_TIMEOUT:    cfg.command_timeout_ms <= cfg_data;
        REG_ACTION_TIMEOUT: cfg.action_timeout_ms  <= cfg_data;
        REG_SETTLE:         cfg.settle_ms          <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/macs_step.sv
// ----------------------------------------------------------------------------
// macs_step
// Sequencer state and the single-pass update that one request applies.
// ----------------------------------------------------------------------------
module macs_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  macs_pkg::item_t   item,
  input  macs_pkg::cfg_t    cfg,
  output macs_pkg::result_t res
);
  import macs_pkg::*;

  `include "assert_macros.svh"

  seq_state_t st;
  seq_state_t st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{main_state: ST_OFF, http_step: HS_IDLE, config_step: CS_ECHO,
              elapsed_ms: '0, wait_limit: '0, response_pending: 1'b0,
              response_flags: '0};
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    res     = '{modem_state: ST_OFF, send_code: SEND_NONE, dtr_drive: DTR_NONE,
                pwrkey_pulse: PWR_NONE, done_valid: 1'b0, done_success: 1'b0};

    // The request's own effect comes first.
    case (item.command)
      CMD_TICK: begin
        if (st_next.elapsed_ms != ELAPSED_MAX) begin
          st_next.elapsed_ms = st_next.elapsed_ms + 16'd1;
        end
      end
      CMD_RESPONSE: begin
        st_next.response_pending = 1'b1;
        st_next.response_flags   = {item.has_error, item.has_code_200, item.has_ok};
      end
      CMD_POWER_ON: begin
        if (st_next.main_state == ST_OFF) begin
          res.pwrkey_pulse   = PWR_ON;
          st_next.main_state = ST_BOOT;
          st_next.elapsed_ms = '0;
          st_next.wait_limit = cfg.boot_wait_ms;
        end
      end
      CMD_POWER_OFF: begin
        st_next.main_state = ST_OFF;
        res.pwrkey_pulse   = PWR_OFF;
      end
      CMD_WAKE: begin
        if (st_next.main_state == ST_SLEEP) begin
          res.dtr_drive      = DTR_LOW;
          st_next.main_state = ST_TX;
          st_next.elapsed_ms = '0;
          st_next.wait_limit = cfg.settle_ms;
        end
      end
      CMD_SEND: begin
        if (item.payload_nonempty) begin
          st_next.http_step = HS_INIT;
          if (st_next.main_state == ST_SLEEP) begin
            res.dtr_drive      = DTR_LOW;
            st_next.main_state = ST_TX;
            st_next.elapsed_ms = '0;
            st_next.wait_limit = cfg.settle_ms;
          end else if (st_next.main_state == ST_NET) begin
            st_next.main_state = ST_TX;
          end
        end
      end
      default: ;
    endcase

    // Then exactly one sequencer step.
    case (st_next.main_state)
      ST_BOOT: begin
        if (st_next.elapsed_ms >= st_next.wait_limit) begin
          st_next.config_step = CS_ECHO;
          res.send_code       = SEND_ECHO_OFF;
          st_next.main_state  = ST_WAIT;
          st_next.elapsed_ms  = '0;
          st_next.wait_limit  = cfg.command_timeout_ms;
        end
      end
      ST_NET: begin
        case (st_next.config_step)
          CS_ECHO: begin
            res.send_code       = SEND_APN_SET;
            st_next.config_step = CS_APN;
            st_next.main_state  = ST_WAIT;
            st_next.elapsed_ms  = '0;
            st_next.wait_limit  = cfg.command_timeout_ms;
          end
          CS_APN: begin
            res.send_code       = SEND_SLEEP_EN;
            st_next.config_step = CS_SLEEP;
            st_next.main_state  = ST_WAIT;
            st_next.elapsed_ms  = '0;
            st_next.wait_limit  = cfg.command_timeout_ms;
          end
          default: begin
            st_next.config_step = CS_DONE;
            res.dtr_drive       = DTR_HIGH;
            st_next.main_state  = ST_SLEEP;
          end
        endcase
      end
      ST_TX: begin
        if (!(st_next.elapsed_ms < cfg.settle_ms && st_next.http_step == HS_INIT)) begin
          case (st_next.http_step)
            HS_INIT: begin
              res.send_code      = SEND_HTTP_INIT;
              st_next.http_step  = HS_URL;
              st_next.main_state = ST_WAIT;
              st_next.elapsed_ms = '0;
              st_next.wait_limit = cfg.command_timeout_ms;
            end
            HS_URL: begin
              res.send_code      = SEND_URL;
              st_next.http_step  = HS_ACTION;
              st_next.main_state = ST_WAIT;
              st_next.elapsed_ms = '0;
              st_next.wait_limit = cfg.command_timeout_ms;
            end
            HS_ACTION: begin
              res.send_code      = SEND_HTTP_ACT;
              st_next.http_step  = HS_DONE;
              st_next.main_state = ST_WAIT;
              st_next.elapsed_ms = '0;
              st_next.wait_limit = cfg.action_timeout_ms;
            end
            HS_DONE: begin
              res.send_code      = SEND_HTTP_TERM;
              st_next.http_step  = HS_IDLE;
              res.dtr_drive      = DTR_HIGH;
              st_next.main_state = ST_SLEEP;
              res.done_valid     = 1'b1;
              res.done_success   = 1'b1;
            end
            default: begin
              st_next.http_step  = HS_IDLE;
              st_next.main_state = ST_SLEEP;
            end
          endcase
        end
      end
      ST_WAIT: begin
        if (st_next.response_pending) begin
          st_next.response_pending = 1'b0;
          if (st_next.response_flags[FLAG_OK] || st_next.response_flags[FLAG_200]) begin
            if (st_next.config_step != CS_DONE && st_next.http_step == HS_IDLE) begin
              st_next.main_state = ST_NET;
            end else begin
              st_next.main_state = ST_TX;
            end
          end else if (st_next.response_flags[FLAG_ERROR]) begin
            st_next.http_step  = HS_IDLE;
            res.dtr_drive      = DTR_HIGH;
            st_next.main_state = ST_SLEEP;
            res.done_valid     = 1'b1;
            res.done_success   = 1'b0;
          end
        end else if (st_next.elapsed_ms >= st_next.wait_limit) begin
          st_next.http_step  = HS_IDLE;
          res.dtr_drive      = DTR_HIGH;
          st_next.main_state = ST_SLEEP;
          res.done_valid     = 1'b1;
          res.done_success   = 1'b0;
        end
      end
      ST_BUSY: ;
      default: ;
    endcase

    res.modem_state = st_next.main_state;
  end

  // A power-off request always leaves the modem off.
  `MACS_ASSERT(a_power_off_ends_off, clk, rst,
    (fire && item.command == CMD_POWER_OFF) |=> (st.main_state == ST_OFF),
    "power off did not leave the sequencer off")

  // Every transmitted command either opens a wait or closes the transaction.
  `MACS_ASSERT(a_send_opens_wait, clk, rst,
    (fire && res.send_code != SEND_NONE) |=>
      (st.main_state == ST_WAIT || st.main_state == ST_SLEEP),
    "command sent without entering a wait or sleep")

endmodule

>>> tb/modem_at_command_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modem_at_command_sequencer_unit_tb
// Self-checking bench for the modem AT command sequencer. A short scripted
// walk through boot, configuration, a failed HTTP transaction and the power
// controls runs first, then random request streams steered by the sequencer's
// predicted state run under several register settings and flow-control mixes.
// Every result is checked against a cycle-free model of the sequencer or, for
// typed script rows, against the row's fixed expected result.
module modem_at_command_sequencer_unit_tb;
  import macs_pkg::*;

  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_PER_PHASE = 105;
  localparam int OPENING_SPLIT = 9;

  typedef struct packed {
    logic [2:0] command;
    logic       has_ok;
    logic       has_code_200;
    logic       has_error;
    logic       payload_nonempty;
  } request_t;

  typedef struct packed {
    request_t    req;
    logic [15:0] repeats;
    logic        typed;
    result_t     want;
  } script_row_t;

  localparam result_t OFF_QUIET  = '{ST_OFF, SEND_NONE, DTR_NONE, PWR_NONE, 1'b0, 1'b0};
  localparam result_t OFF_PULSE  = '{ST_OFF, SEND_NONE, DTR_NONE, PWR_OFF, 1'b0, 1'b0};
  localparam result_t BOOT_QUIET = '{ST_BOOT, SEND_NONE, DTR_NONE, PWR_NONE, 1'b0, 1'b0};
  localparam result_t BOOT_PULSE = '{ST_BOOT, SEND_NONE, DTR_NONE, PWR_ON, 1'b0, 1'b0};

  // Rows before OPENING_SPLIT run at the reset register values, the rest with
  // short boot, timeout and settle times.
  localparam script_row_t OPENING [0:26] = '{
    '{'{CMD_WAKE,      1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b1, OFF_QUIET},
    '{'{CMD_SEND,      1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b1, OFF_QUIET},
    '{'{CMD_RSVD6,     1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b1, OFF_QUIET},
    '{'{CMD_RSVD7,     1'b1, 1'b1, 1'b1, 1'b1}, 16'd1,  1'b1, OFF_QUIET},
    '{'{CMD_POWER_ON,  1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b1, BOOT_PULSE},
    '{'{CMD_POWER_ON,  1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b1, BOOT_QUIET},
    '{'{CMD_RESPONSE,  1'b0, 1'b0, 1'b1, 1'b0}, 16'd1,  1'b1, BOOT_QUIET},
    '{'{CMD_TICK,      1'b0, 1'b0, 1'b0, 1'b0}, 16'd40, 1'b0, '0},
    '{'{CMD_POWER_OFF, 1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b1, OFF_PULSE},
    '{'{CMD_POWER_ON,  1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b1, BOOT_PULSE},
    '{'{CMD_TICK,      1'b0, 1'b0, 1'b0, 1'b0}, 16'd23, 1'b0, '0},
    '{'{CMD_TICK,      1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b0, '0},
    '{'{CMD_TICK,      1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b0, '0},
    '{'{CMD_RESPONSE,  1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b0, '0},
    '{'{CMD_SEND,      1'b0, 1'b0, 1'b0, 1'b1}, 16'd1,  1'b0, '0},
    '{'{CMD_TICK,      1'b0, 1'b0, 1'b0, 1'b0}, 16'd4,  1'b0, '0},
    '{'{CMD_RESPONSE,  1'b1, 1'b0, 1'b1, 1'b0}, 16'd1,  1'b0, '0},
    '{'{CMD_RSVD6,     1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b0, '0},
    '{'{CMD_RESPONSE,  1'b0, 1'b1, 1'b0, 1'b0}, 16'd1,  1'b0, '0},
    '{'{CMD_TICK,      1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b0, '0},
    '{'{CMD_TICK,      1'b0, 1'b0, 1'b0, 1'b0}, 16'd12, 1'b0, '0},
    '{'{CMD_WAKE,      1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b0, '0},
    '{'{CMD_SEND,      1'b0, 1'b0, 1'b0, 1'b1}, 16'd1,  1'b0, '0},
    '{'{CMD_POWER_OFF, 1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b1, OFF_PULSE},
    '{'{CMD_RESPONSE,  1'b1, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b1, OFF_QUIET},
    '{'{CMD_POWER_ON,  1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b1, BOOT_PULSE},
    '{'{CMD_POWER_OFF, 1'b0, 1'b0, 1'b0, 1'b0}, 16'd1,  1'b1, OFF_PULSE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [2:0]  command = 3'd0;
  logic        has_ok = 1'b0;
  logic        has_code_200 = 1'b0;
  logic        has_error = 1'b0;
  logic        payload_nonempty = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [2:0]  modem_state;
  logic [2:0]  send_code;
  logic [1:0]  dtr_drive;
  logic [1:0]  pwrkey_pulse;
  logic        done_valid;
  logic        done_success;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int bad_results = 0;
  int quiet_cycles = 0;
  result_t due_results [$];

  cfg_t         seq_regs;
  state_t       seq_main;
  http_step_t   seq_http;
  config_step_t seq_cfg_step;
  logic [15:0]  seq_elapsed;
  logic [15:0]  seq_limit;
  logic         seq_pending;
  logic [2:0]   seq_flags;

  modem_at_command_sequencer_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready),
    .command(command), .has_ok(has_ok), .has_code_200(has_code_200),
    .has_error(has_error), .payload_nonempty(payload_nonempty),
    .result_valid(result_valid), .result_ready(result_ready),
    .modem_state(modem_state), .send_code(send_code), .dtr_drive(dtr_drive),
    .pwrkey_pulse(pwrkey_pulse), .done_valid(done_valid), .done_success(done_success)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void seq_reset();
    seq_regs.boot_wait_ms = BOOT_WAIT_RST;
    seq_regs.command_timeout_ms = CMD_TIMEOUT_RST;
    seq_regs.action_timeout_ms = ACTION_TIMEOUT_RST;
    seq_regs.settle_ms = SETTLE_RST;
    seq_main = ST_OFF;
    seq_http = HS_IDLE;
    seq_cfg_step = CS_ECHO;
    seq_elapsed = '0;
    seq_limit = '0;
    seq_pending = 1'b0;
    seq_flags = '0;
  endfunction

  function automatic void arm_wait(input logic [15:0] lim);
    seq_main = ST_WAIT;
    seq_elapsed = '0;
    seq_limit = lim;
  endfunction

  function automatic void abort_to_sleep(inout result_t r);
    seq_http = HS_IDLE;
    seq_main = ST_SLEEP;
    r.dtr_drive = DTR_HIGH;
    r.done_valid = 1'b1;
    r.done_success = 1'b0;
  endfunction

  function automatic void wake_modem(inout result_t r);
    if (seq_main == ST_SLEEP) begin
      r.dtr_drive = DTR_LOW;
      seq_main = ST_TX;
      seq_elapsed = '0;
      seq_limit = seq_regs.settle_ms;
    end
  endfunction

  function automatic result_t sequencer_step(input request_t q);
    result_t r;
    r = '0;
    case (q.command)
      CMD_TICK: begin
        if (seq_elapsed != ELAPSED_MAX) seq_elapsed = seq_elapsed + 16'd1;
      end
      CMD_RESPONSE: begin
        seq_pending = 1'b1;
        seq_flags[FLAG_OK] = q.has_ok;
        seq_flags[FLAG_200] = q.has_code_200;
        seq_flags[FLAG_ERROR] = q.has_error;
      end
      CMD_POWER_ON: begin
        if (seq_main == ST_OFF) begin
          r.pwrkey_pulse = PWR_ON;
          seq_main = ST_BOOT;
          seq_elapsed = '0;
          seq_limit = seq_regs.boot_wait_ms;
        end
      end
      CMD_POWER_OFF: begin
        seq_main = ST_OFF;
        r.pwrkey_pulse = PWR_OFF;
      end
      CMD_WAKE: wake_modem(r);
      CMD_SEND: begin
        if (q.payload_nonempty) begin
          seq_http = HS_INIT;
          if (seq_main == ST_SLEEP) wake_modem(r);
          else if (seq_main == ST_NET) seq_main = ST_TX;
        end
      end
      default: ;
    endcase

    case (seq_main)
      ST_BOOT: begin
        if (seq_elapsed >= seq_limit) begin
          seq_cfg_step = CS_ECHO;
          r.send_code = SEND_ECHO_OFF;
          arm_wait(seq_regs.command_timeout_ms);
        end
      end
      ST_NET: begin
        case (seq_cfg_step)
          CS_ECHO: begin
            r.send_code = SEND_APN_SET;
            seq_cfg_step = CS_APN;
            arm_wait(seq_regs.command_timeout_ms);
          end
          CS_APN: begin
            r.send_code = SEND_SLEEP_EN;
            seq_cfg_step = CS_SLEEP;
            arm_wait(seq_regs.command_timeout_ms);
          end
          default: begin
            seq_cfg_step = CS_DONE;
            r.dtr_drive = DTR_HIGH;
            seq_main = ST_SLEEP;
          end
        endcase
      end
      ST_TX: begin
        if (!(seq_elapsed < seq_regs.settle_ms && seq_http == HS_INIT)) begin
          case (seq_http)
            HS_INIT: begin
              r.send_code = SEND_HTTP_INIT;
              seq_http = HS_URL;
              arm_wait(seq_regs.command_timeout_ms);
            end
            HS_URL: begin
              r.send_code = SEND_URL;
              seq_http = HS_ACTION;
              arm_wait(seq_regs.command_timeout_ms);
            end
            HS_ACTION: begin
              r.send_code = SEND_HTTP_ACT;
              seq_http = HS_DONE;
              arm_wait(seq_regs.action_timeout_ms);
            end
            HS_DONE: begin
              r.send_code = SEND_HTTP_TERM;
              seq_http = HS_IDLE;
              r.dtr_drive = DTR_HIGH;
              seq_main = ST_SLEEP;
              r.done_valid = 1'b1;
              r.done_success = 1'b1;
            end
            default: begin
              seq_http = HS_IDLE;
              seq_main = ST_SLEEP;
            end
          endcase
        end
      end
      ST_WAIT: begin
        if (seq_pending) begin
          seq_pending = 1'b0;
          if (seq_flags[FLAG_OK] || seq_flags[FLAG_200]) begin
            if (seq_cfg_step != CS_DONE && seq_http == HS_IDLE) seq_main = ST_NET;
            else seq_main = ST_TX;
          end else if (seq_flags[FLAG_ERROR]) begin
            abort_to_sleep(r);
          end
        end else if (seq_elapsed >= seq_limit) begin
          abort_to_sleep(r);
        end
      end
      default: ;
    endcase

    r.modem_state = seq_main;
    return r;
  endfunction

  // Mostly requests that move the sequencer forward from its current state,
  // with a share of arbitrary requests mixed in.
  function automatic request_t pick_request();
    request_t q;
    int unsigned roll;
    q.command = 3'($urandom_range(7));
    q.has_ok = 1'($urandom_range(1));
    q.has_code_200 = 1'($urandom_range(1));
    q.has_error = 1'($urandom_range(1));
    q.payload_nonempty = 1'($urandom_range(1));
    if ($urandom_range(99) < 20) return q;
    roll = $urandom_range(99);
    case (seq_main)
      ST_OFF: q.command = CMD_POWER_ON;
      ST_BOOT: q.command = (roll < 90) ? CMD_TICK : CMD_RESPONSE;
      ST_WAIT: begin
        if (roll < 55) begin
          q.command = CMD_RESPONSE;
          q.has_code_200 = q.has_code_200 | ~q.has_ok;
        end else if (roll < 65) begin
          q.command = CMD_RESPONSE;
          q.has_ok = 1'b0;
          q.has_code_200 = 1'b0;
          q.has_error = 1'b1;
        end else if (roll < 70) begin
          q.command = CMD_RESPONSE;
          q.has_ok = 1'b0;
          q.has_code_200 = 1'b0;
          q.has_error = 1'b0;
        end else if (roll < 75) begin
          q.command = CMD_SEND;
          q.payload_nonempty = 1'b1;
        end else begin
          q.command = CMD_TICK;
        end
      end
      ST_SLEEP: begin
        if (roll < 70) begin
          q.command = CMD_SEND;
          q.payload_nonempty = 1'b1;
        end else if (roll < 90) begin
          q.command = CMD_WAKE;
        end else begin
          q.command = CMD_TICK;
        end
      end
      ST_TX: q.command = CMD_TICK;
      default: ;
    endcase
    return q;
  endfunction

  task automatic issue(input request_t q, input logic typed, input result_t want);
    result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    command <= q.command;
    has_ok <= q.has_ok;
    has_code_200 <= q.has_code_200;
    has_error <= q.has_error;
    payload_nonempty <= q.payload_nonempty;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    r = sequencer_step(q);
    due_results.push_back(typed ? want : r);
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_BOOT_WAIT:      seq_regs.boot_wait_ms = value;
      REG_CMD_TIMEOUT:    seq_regs.command_timeout_ms = value;
      REG_ACTION_TIMEOUT: seq_regs.action_timeout_ms = value;
      default:            seq_regs.settle_ms = value;
    endcase
  endtask

  task automatic load_regs(input logic [15:0] boot, input logic [15:0] cmd_to,
                           input logic [15:0] act_to, input logic [15:0] settle);
    write_reg(REG_BOOT_WAIT, boot);
    write_reg(REG_CMD_TIMEOUT, cmd_to);
    write_reg(REG_ACTION_TIMEOUT, act_to);
    write_reg(REG_SETTLE, settle);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  always @(negedge clk) begin
    result_ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && result_valid && result_ready) begin
      got = {modem_state, send_code, dtr_drive, pwrkey_pulse, done_valid, done_success};
      if (due_results.size() == 0) begin
        bad_results <= bad_results + 1;
        if (bad_results < 10) $display("result with no request outstanding: %b", got);
      end else begin
        want = due_results.pop_front();
        if (got.modem_state !== want.modem_state || got.send_code !== want.send_code ||
            got.dtr_drive !== want.dtr_drive || got.pwrkey_pulse !== want.pwrkey_pulse ||
            got.done_valid !== want.done_valid || got.done_success !== want.done_success) begin
          bad_results <= bad_results + 1;
          if (bad_results < 10) begin
            $display("mismatch at %0t (expected/actual): state %0d/%0d send %0d/%0d",
                     $realtime, want.modem_state, got.modem_state,
                     want.send_code, got.send_code);
            $display("  dtr %0d/%0d pwr %0d/%0d done %0b/%0b ok %0b/%0b",
                     want.dtr_drive, got.dtr_drive, want.pwrkey_pulse, got.pwrkey_pulse,
                     want.done_valid, got.done_valid, want.done_success, got.done_success);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("modem_at_command_sequencer_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    request_t q;
    seq_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 14;
    stall_pct = 14;
    for (int i = 0; i < $size(OPENING); i++) begin
      if (i == OPENING_SPLIT) begin
        drain_results();
        load_regs(16'd24, 16'd6, 16'd12, 16'd4);
      end
      for (int k = 0; k < OPENING[i].repeats; k++) begin
        issue(OPENING[i].req, OPENING[i].typed, OPENING[i].want);
      end
    end
    drain_results();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          load_regs(16'd3, 16'd4, 16'd5, 16'd2);
        end
        1: begin
          send_idle_pct = 77;
          stall_pct = 0;
          load_regs(16'd0, 16'd0, 16'd0, 16'd0);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 77;
          load_regs(16'd2, 16'hFFFF, 16'hFFFF, 16'd3);
        end
        3: begin
          send_idle_pct = 14;
          stall_pct = 14;
          load_regs(16'($urandom_range(6)), 16'($urandom_range(6)),
                    16'($urandom_range(6)), 16'($urandom_range(6)));
        end
        default: begin
          send_idle_pct = 0;
          stall_pct = 0;
          load_regs(16'($urandom_range(6)), 16'($urandom_range(6)),
                    16'($urandom_range(6)), 16'($urandom_range(6)));
        end
      endcase
      repeat (RANDOM_PER_PHASE) issue(pick_request(), 1'b0, '0);
      drain_results();
    end

    // Longest boot wait and settle time.
    send_idle_pct = 0;
    stall_pct = 0;
    load_regs(16'hFFFF, 16'd1, 16'd1, 16'hFFFF);
    q = '0;
    q.command = CMD_POWER_OFF;
    issue(q, 1'b0, '0);
    q.command = CMD_POWER_ON;
    issue(q, 1'b0, '0);
    q.command = CMD_TICK;
    repeat (16) issue(q, 1'b0, '0);
    q.command = CMD_SEND;
    q.payload_nonempty = 1'b1;
    issue(q, 1'b0, '0);
    q.command = CMD_TICK;
    repeat (4) issue(q, 1'b0, '0);
    q.command = CMD_POWER_OFF;
    issue(q, 1'b0, '0);
    drain_results();

    if (bad_results == 0) begin
      $display("modem_at_command_sequencer_unit verification clean");
    end else begin
      $display("modem_at_command_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/macs_pkg.sv
rtl/macs_regs.sv
rtl/macs_step.sv
rtl/modem_at_command_sequencer_unit.sv
tb/modem_at_command_sequencer_unit_tb.sv
